// File: rtl/rlad_pkg.sv
// Shared types and constants for the record list block.
// Used by rlad_ctrl, rlad_dpath and record_list_append_delete_by_key_core.
package rlad_pkg;

  localparam int unsigned RLAD_DEPTH = 32;

  localparam int unsigned ID_HIGH_W = 64;
  localparam int unsigned ID_LOW_W  = 40;
  localparam int unsigned COURSE_W  = 40;
  localparam int unsigned GRADE_W   = 10;
  localparam int unsigned ABS_W     = 16;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_DUMP   = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_APPENDED = 3'd0,
    ST_FULL     = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_NONE     = 3'd3,
    ST_ENTRY    = 3'd4,
    ST_EMPTY    = 3'd5
  } status_e;

  typedef struct packed {
    logic [ID_HIGH_W-1:0] id_high;
    logic [ID_LOW_W-1:0]  id_low;
    logic [COURSE_W-1:0]  course;
    logic [GRADE_W-1:0]   grade;
    logic [ABS_W-1:0]     absences;
  } rec_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    in_cap;
    logic    mem_rd;
    logic    mem_wr;
    logic    wr_from_in;
    logic    cnt_inc;
    logic    cnt_load;
    logic    out_load;
    status_e out_status;
    logic    out_last;
    logic    out_rec;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic key_match;
    logic out_free;
    logic full;
    logic empty;
  } sts_t;

endpackage

// File: rtl/rlad_dpath.sv
// Datapath of the record list: record memory, record count, request
// registers and the result register. Depends on rlad_pkg.
module rlad_dpath import rlad_pkg::*; #(
  parameter int unsigned DEPTH = RLAD_DEPTH,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  input  logic [AW-1:0]        rd_addr_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  logic [CW-1:0]        cnt_val_i,
  output sts_t                 sts_o,
  output logic [CW-1:0]        count_o,
  input  logic [ID_HIGH_W-1:0] id_high_i,
  input  logic [ID_LOW_W-1:0]  id_low_i,
  input  logic [COURSE_W-1:0]  course_code_i,
  input  logic [GRADE_W-1:0]   grade_i,
  input  logic [ABS_W-1:0]     absences_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           status_o,
  output logic [ID_HIGH_W-1:0] out_id_high_o,
  output logic [ID_LOW_W-1:0]  out_id_low_o,
  output logic [COURSE_W-1:0]  out_course_o,
  output logic [GRADE_W-1:0]   out_grade_o,
  output logic [ABS_W-1:0]     out_absences_o,
  output logic [CW-1:0]        entry_count_o,
  output logic                 last_o
);

  rec_t          mem [DEPTH];
  rec_t          in_rec_q;
  rec_t          rd_data_q;
  rec_t          wr_data;
  logic [CW-1:0] count_q, count_d;
  logic          out_valid_q, out_valid_d;
  status_e       status_q;
  rec_t          out_rec_q;
  logic [CW-1:0] entry_count_q;
  logic          last_q;
  logic          out_free;

  assign out_free = !out_valid_q || !out_stall_i;
  assign wr_data  = cmd_i.wr_from_in ? in_rec_q : rd_data_q;

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_load) begin
      count_d = cnt_val_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem[wr_addr_i] <= wr_data;
    end
    if (cmd_i.mem_rd) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_cap) begin
      in_rec_q.id_high  <= id_high_i;
      in_rec_q.id_low   <= id_low_i;
      in_rec_q.course   <= course_code_i;
      in_rec_q.grade    <= grade_i;
      in_rec_q.absences <= absences_i;
    end
    if (cmd_i.out_load) begin
      status_q      <= cmd_i.out_status;
      out_rec_q     <= cmd_i.out_rec ? rd_data_q : '0;
      entry_count_q <= count_d;
      last_q        <= cmd_i.out_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.key_match = (rd_data_q.course == in_rec_q.course);
  assign sts_o.out_free  = out_free;
  assign sts_o.full      = (count_q == CW'(DEPTH));
  assign sts_o.empty     = (count_q == '0);
  assign count_o         = count_q;

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_id_high_o  = out_rec_q.id_high;
  assign out_id_low_o   = out_rec_q.id_low;
  assign out_course_o   = out_rec_q.course;
  assign out_grade_o    = out_rec_q.grade;
  assign out_absences_o = out_rec_q.absences;
  assign entry_count_o  = entry_count_q;
  assign last_o         = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("record count exceeds table depth");

  a_append_at_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.mem_wr && cmd_i.cnt_inc) |-> (CW'(wr_addr_i) == count_q))
    else $error("append does not write at the tail");

  a_write_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.mem_wr && !cmd_i.cnt_inc) |-> (CW'(wr_addr_i) < count_q))
    else $error("compaction write outside the stored records");

endmodule

// File: rtl/rlad_ctrl.sv
// Controller of the record list: sequences append, delete compaction and dump.
// Drives the datapath through cmd_t and reads sts_t. Depends on rlad_pkg.
module rlad_ctrl import rlad_pkg::*; #(
  parameter int unsigned DEPTH = RLAD_DEPTH,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    action_i,
  input  sts_t          sts_i,
  input  logic [CW-1:0] count_i,
  output cmd_t          cmd_o,
  output logic [AW-1:0] rd_addr_o,
  output logic [AW-1:0] wr_addr_o,
  output logic [CW-1:0] cnt_val_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_DEL,
    S_DEL_DONE,
    S_DUMP_RD,
    S_DUMP_WR,
    S_EMPTY
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] r_q, r_d;
  logic [CW-1:0] w_q, w_d;
  logic          pend_q, pend_d;
  logic [CW-1:0] r_next;
  logic [CW-1:0] w_next;
  logic          issue;

  assign r_next    = r_q + CW'(1);
  assign w_next    = w_q + CW'(1);
  assign issue     = (r_q != count_i);
  assign cnt_val_o = w_q;

  always_comb begin
    cmd_o      = '0;
    rd_addr_o  = '0;
    wr_addr_o  = '0;
    state_d    = state_q;
    r_d        = r_q;
    w_d        = w_q;
    pend_d     = pend_q;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_cap = 1'b1;
          r_d    = '0;
          w_d    = '0;
          pend_d = 1'b0;
          case (action_i)
            ACT_APPEND: state_d = S_APPEND;
            ACT_DELETE: state_d = S_DEL;
            ACT_DUMP:   state_d = sts_i.empty ? S_EMPTY : S_DUMP_RD;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_APPEND: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          if (sts_i.full) begin
            cmd_o.out_status = ST_FULL;
          end else begin
            cmd_o.out_status = ST_APPENDED;
            cmd_o.mem_wr     = 1'b1;
            cmd_o.wr_from_in = 1'b1;
            cmd_o.cnt_inc    = 1'b1;
            wr_addr_o        = count_i[AW-1:0];
          end
          state_d = S_IDLE;
        end
      end
      S_DEL: begin
        // Reads run one record ahead of the compare; kept records are
        // written back at the compaction pointer, which never passes the reads.
        if (issue) begin
          cmd_o.mem_rd = 1'b1;
          rd_addr_o    = r_q[AW-1:0];
          r_d          = r_next;
        end
        pend_d = issue;
        if (pend_q && !sts_i.key_match) begin
          cmd_o.mem_wr = 1'b1;
          wr_addr_o    = w_q[AW-1:0];
          w_d          = w_next;
        end
        if (!issue && !pend_q) begin
          state_d = S_DEL_DONE;
        end
      end
      S_DEL_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.cnt_load   = 1'b1;
          cmd_o.out_load   = 1'b1;
          cmd_o.out_last   = 1'b1;
          cmd_o.out_status = (w_q != count_i) ? ST_REMOVED : ST_NONE;
          state_d          = S_IDLE;
        end
      end
      S_DUMP_RD: begin
        cmd_o.mem_rd = 1'b1;
        rd_addr_o    = r_q[AW-1:0];
        state_d      = S_DUMP_WR;
      end
      S_DUMP_WR: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_rec    = 1'b1;
          cmd_o.out_status = ST_ENTRY;
          if (r_next == count_i) begin
            cmd_o.out_last = 1'b1;
            state_d        = S_IDLE;
          end else begin
            // Fetch the next record while this one moves to the output.
            cmd_o.mem_rd = 1'b1;
            rd_addr_o    = r_next[AW-1:0];
            r_d          = r_next;
          end
        end
      end
      S_EMPTY: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_last   = 1'b1;
          cmd_o.out_status = ST_EMPTY;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      r_q     <= '0;
      w_q     <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      w_q     <= w_d;
      pend_q  <= pend_d;
    end
  end

  a_write_behind_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEL) |-> (w_q <= r_q && r_q <= count_i))
    else $error("compaction pointer passed the read pointer");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded over a waiting result");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (action_i == ACT_APPEND ||
     action_i == ACT_DELETE || action_i == ACT_DUMP)) |=> in_stall_o)
    else $error("request taken while another is in progress");

endmodule

// File: rtl/record_list_append_delete_by_key_core.sv
// Append: the request is captured, then the result is registered once the output is
// free. Delete: one stored record per cycle is read, compared and, if kept, written
// back, then the result. Dump: the first record is read, then loaded as the first
// entry, then one entry per cycle while the output is not stalled; the single memory
// read port sets that pace. One request at a time: the next request is taken at the
// edge after the last result is loaded. Reset clears the record count, no clearing pass.
module record_list_append_delete_by_key_core import rlad_pkg::*; #(
  parameter int unsigned DEPTH = RLAD_DEPTH,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           action_i,
  input  logic [ID_HIGH_W-1:0] id_high_i,
  input  logic [ID_LOW_W-1:0]  id_low_i,
  input  logic [COURSE_W-1:0]  course_code_i,
  input  logic [GRADE_W-1:0]   grade_i,
  input  logic [ABS_W-1:0]     absences_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           status_o,
  output logic [ID_HIGH_W-1:0] out_id_high_o,
  output logic [ID_LOW_W-1:0]  out_id_low_o,
  output logic [COURSE_W-1:0]  out_course_o,
  output logic [GRADE_W-1:0]   out_grade_o,
  output logic [ABS_W-1:0]     out_absences_o,
  output logic [CW-1:0]        entry_count_o,
  output logic                 last_o
);

  cmd_t          cmd;
  sts_t          sts;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [CW-1:0] cnt_val;
  logic [CW-1:0] count;

  rlad_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .sts_i      (sts),
    .count_i    (count),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr),
    .wr_addr_o  (wr_addr),
    .cnt_val_o  (cnt_val)
  );

  rlad_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .rd_addr_i      (rd_addr),
    .wr_addr_i      (wr_addr),
    .cnt_val_i      (cnt_val),
    .sts_o          (sts),
    .count_o        (count),
    .id_high_i      (id_high_i),
    .id_low_i       (id_low_i),
    .course_code_i  (course_code_i),
    .grade_i        (grade_i),
    .absences_i     (absences_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .out_id_high_o  (out_id_high_o),
    .out_id_low_o   (out_id_low_o),
    .out_course_o   (out_course_o),
    .out_grade_o    (out_grade_o),
    .out_absences_o (out_absences_o),
    .entry_count_o  (entry_count_o),
    .last_o         (last_o)
  );

endmodule
